FILE: sv/sndc_pkg.sv
// Shared constants and register codes for the strided N-d copy address generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sndc_pkg;

  localparam int unsigned MAX_DIMS_DEF   = 4;
  localparam int unsigned FIELD_BITS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF  = 48;

  localparam int unsigned PACK_BITS      = 64;
  localparam int unsigned DIM_CNT_BITS   = 3;
  localparam int unsigned BYTES_BITS     = 8;
  localparam int unsigned APB_DATA_BITS  = 64;
  localparam int unsigned APB_ADDR_BITS  = 6;
  localparam int unsigned IN_DATA_BITS   = 8;
  localparam int unsigned OUT_DEPTH      = 4;

  localparam logic [BYTES_BITS-1:0] ITEM_BYTES_RST = 8'd4;

  typedef enum logic [2:0] {
    REG_DIM_COUNT     = 3'd0,
    REG_ITEM_BYTES    = 3'd1,
    REG_EXTENT        = 3'd2,
    REG_SRC_STRIDES   = 3'd3,
    REG_DST_STRIDES   = 3'd4,
    REG_SRC_START     = 3'd5,
    REG_SRC_BASE      = 3'd6,
    REG_DST_BASE      = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

FILE: sv/sndc_cfg_regs.sv
// APB configuration register file of the strided copy address generator.
// Depends on sndc_pkg for register codes, widths and reset values.
`default_nettype none

module sndc_cfg_regs #(
  parameter int unsigned ADDR_BITS = sndc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sndc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [sndc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [sndc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                      pready,
  output logic      [sndc_pkg::DIM_CNT_BITS-1:0]    dim_count_o,
  output logic      [sndc_pkg::BYTES_BITS-1:0]      item_bytes_o,
  output logic      [sndc_pkg::PACK_BITS-1:0]       extent_o,
  output logic      [sndc_pkg::PACK_BITS-1:0]       src_strides_o,
  output logic      [sndc_pkg::PACK_BITS-1:0]       dst_strides_o,
  output logic      [sndc_pkg::PACK_BITS-1:0]       src_start_o,
  output logic      [ADDR_BITS-1:0]                 src_base_o,
  output logic      [ADDR_BITS-1:0]                 dst_base_o
);
  import sndc_pkg::*;

  logic [DIM_CNT_BITS-1:0] dim_count_q;
  logic [BYTES_BITS-1:0]   item_bytes_q;
  logic [PACK_BITS-1:0]    extent_q;
  logic [PACK_BITS-1:0]    src_strides_q;
  logic [PACK_BITS-1:0]    dst_strides_q;
  logic [PACK_BITS-1:0]    src_start_q;
  logic [ADDR_BITS-1:0]    src_base_q;
  logic [ADDR_BITS-1:0]    dst_base_q;
  reg_idx_e                reg_idx;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_BITS-1:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q   <= '0;
      item_bytes_q  <= ITEM_BYTES_RST;
      extent_q      <= '0;
      src_strides_q <= '0;
      dst_strides_q <= '0;
      src_start_q   <= '0;
      src_base_q    <= '0;
      dst_base_q    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIM_COUNT:   dim_count_q   <= pwdata[DIM_CNT_BITS-1:0];
        REG_ITEM_BYTES:  item_bytes_q  <= pwdata[BYTES_BITS-1:0];
        REG_EXTENT:      extent_q      <= pwdata[PACK_BITS-1:0];
        REG_SRC_STRIDES: src_strides_q <= pwdata[PACK_BITS-1:0];
        REG_DST_STRIDES: dst_strides_q <= pwdata[PACK_BITS-1:0];
        REG_SRC_START:   src_start_q   <= pwdata[PACK_BITS-1:0];
        REG_SRC_BASE:    src_base_q    <= pwdata[ADDR_BITS-1:0];
        REG_DST_BASE:    dst_base_q    <= pwdata[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIM_COUNT:   prdata = APB_DATA_BITS'(dim_count_q);
      REG_ITEM_BYTES:  prdata = APB_DATA_BITS'(item_bytes_q);
      REG_EXTENT:      prdata = APB_DATA_BITS'(extent_q);
      REG_SRC_STRIDES: prdata = APB_DATA_BITS'(src_strides_q);
      REG_DST_STRIDES: prdata = APB_DATA_BITS'(dst_strides_q);
      REG_SRC_START:   prdata = APB_DATA_BITS'(src_start_q);
      REG_SRC_BASE:    prdata = APB_DATA_BITS'(src_base_q);
      REG_DST_BASE:    prdata = APB_DATA_BITS'(dst_base_q);
      default:         prdata = '0;
    endcase
  end

  assign dim_count_o   = dim_count_q;
  assign item_bytes_o  = item_bytes_q;
  assign extent_o      = extent_q;
  assign src_strides_o = src_strides_q;
  assign dst_strides_o = dst_strides_q;
  assign src_start_o   = src_start_q;
  assign src_base_o    = src_base_q;
  assign dst_base_o    = dst_base_q;

endmodule

`default_nettype wire

FILE: sv/sndc_index_walker.sv
// Odometer index counters and the first pipeline register of the address generator.
// Depends on sndc_pkg for field and register widths.
`default_nettype none

module sndc_index_walker #(
  parameter int unsigned MAX_DIMS   = sndc_pkg::MAX_DIMS_DEF,
  parameter int unsigned FIELD_BITS = sndc_pkg::FIELD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic                               restart_i,
  input  wire logic [sndc_pkg::DIM_CNT_BITS-1:0]  dim_count_i,
  input  wire logic [sndc_pkg::BYTES_BITS-1:0]    item_bytes_i,
  input  wire logic [sndc_pkg::PACK_BITS-1:0]     extent_i,
  output logic                                    valid_o,
  output logic      [MAX_DIMS-1:0][FIELD_BITS-1:0] idx_o,
  output logic      [MAX_DIMS-1:0]                used_o,
  output logic                                    last_o,
  output logic      [sndc_pkg::BYTES_BITS-1:0]    bytes_o
);
  import sndc_pkg::*;

  logic [MAX_DIMS-1:0][FIELD_BITS-1:0] cnt_q, cnt_d;
  logic [MAX_DIMS-1:0][FIELD_BITS-1:0] idx_cur;
  logic [MAX_DIMS-1:0]                 used;
  logic                                done;
  logic                                valid_q;
  logic [MAX_DIMS-1:0][FIELD_BITS-1:0] idx_q;
  logic [MAX_DIMS-1:0]                 used_q;
  logic                                last_q;
  logic [BYTES_BITS-1:0]               bytes_q;

  always_comb begin
    logic                  carry;
    logic [FIELD_BITS:0]   nxt;
    logic [FIELD_BITS-1:0] ext;
    carry   = 1'b1;
    idx_cur = restart_i ? '0 : cnt_q;
    cnt_d   = idx_cur;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      used[k] = (32'(dim_count_i) > k);
      ext     = extent_i[k*FIELD_BITS +: FIELD_BITS];
      if (ext == '0) begin
        ext = FIELD_BITS'(1);
      end
      nxt = {1'b0, idx_cur[k]} + (FIELD_BITS+1)'(1);
      if (used[k] && carry) begin
        if (nxt < {1'b0, ext}) begin
          cnt_d[k] = nxt[FIELD_BITS-1:0];
          carry    = 1'b0;
        end else begin
          cnt_d[k] = '0;
        end
      end
    end
    done = carry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
      if (accept_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      idx_q   <= idx_cur;
      used_q  <= used;
      last_q  <= done;
      bytes_q <= item_bytes_i;
    end
  end

  assign valid_o = valid_q;
  assign idx_o   = idx_q;
  assign used_o  = used_q;
  assign last_o  = last_q;
  assign bytes_o = bytes_q;

endmodule

`default_nettype wire

FILE: sv/sndc_addr_pipe.sv
// Per-dimension offset products and the base-plus-offsets adder of the address generator.
// Depends on sndc_pkg for field and register widths.
`default_nettype none

module sndc_addr_pipe #(
  parameter int unsigned MAX_DIMS   = sndc_pkg::MAX_DIMS_DEF,
  parameter int unsigned FIELD_BITS = sndc_pkg::FIELD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = sndc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic [MAX_DIMS-1:0][FIELD_BITS-1:0] idx_i,
  input  wire logic [MAX_DIMS-1:0]                 used_i,
  input  wire logic                                last_i,
  input  wire logic [sndc_pkg::BYTES_BITS-1:0]     bytes_i,
  input  wire logic [sndc_pkg::PACK_BITS-1:0]      src_strides_i,
  input  wire logic [sndc_pkg::PACK_BITS-1:0]      dst_strides_i,
  input  wire logic [sndc_pkg::PACK_BITS-1:0]      src_start_i,
  input  wire logic [ADDR_BITS-1:0]                src_base_i,
  input  wire logic [ADDR_BITS-1:0]                dst_base_i,
  output logic                                     valid_o,
  output logic      [ADDR_BITS-1:0]                src_addr_o,
  output logic      [ADDR_BITS-1:0]                dst_addr_o,
  output logic      [sndc_pkg::BYTES_BITS-1:0]     bytes_o,
  output logic                                     last_o
);
  import sndc_pkg::*;

  localparam int unsigned SPROD_W = 2 * FIELD_BITS + 1;
  localparam int unsigned DPROD_W = 2 * FIELD_BITS;
  localparam int unsigned SUM_W   = SPROD_W + $clog2(MAX_DIMS + 1);
  localparam int unsigned ACC_W   = (ADDR_BITS > SUM_W) ? ADDR_BITS : SUM_W;

  logic [MAX_DIMS-1:0][SPROD_W-1:0] sprod_d, sprod_q;
  logic [MAX_DIMS-1:0][DPROD_W-1:0] dprod_d, dprod_q;
  logic                             valid_q;
  logic                             last_q;
  logic [BYTES_BITS-1:0]            bytes_q;
  logic [ACC_W-1:0]                 src_acc;
  logic [ACC_W-1:0]                 dst_acc;

  always_comb begin
    logic [FIELD_BITS:0] sidx;
    for (int k = 0; k < MAX_DIMS; k++) begin
      sidx = {1'b0, idx_i[k]} + {1'b0, src_start_i[k*FIELD_BITS +: FIELD_BITS]};
      sprod_d[k] = used_i[k] ?
                   SPROD_W'(sidx) * SPROD_W'(src_strides_i[k*FIELD_BITS +: FIELD_BITS]) : '0;
      dprod_d[k] = used_i[k] ?
                   DPROD_W'(idx_i[k]) * DPROD_W'(dst_strides_i[k*FIELD_BITS +: FIELD_BITS])
                   : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sprod_q <= sprod_d;
      dprod_q <= dprod_d;
      last_q  <= last_i;
      bytes_q <= bytes_i;
    end
  end

  always_comb begin
    src_acc = ACC_W'(src_base_i);
    dst_acc = ACC_W'(dst_base_i);
    for (int k = 0; k < MAX_DIMS; k++) begin
      src_acc = src_acc + ACC_W'(sprod_q[k]);
      dst_acc = dst_acc + ACC_W'(dprod_q[k]);
    end
  end

  assign valid_o    = valid_q;
  assign src_addr_o = src_acc[ADDR_BITS-1:0];
  assign dst_addr_o = dst_acc[ADDR_BITS-1:0];
  assign bytes_o    = bytes_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

FILE: sv/sndc_out_fifo.sv
// Small register FIFO holding finished moves until the downstream side takes them.
// Depends on sndc_pkg for the default depth.
`default_nettype none

module sndc_out_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sndc_pkg::OUT_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);
  import sndc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/strided_nd_copy_address_generator_top.sv
// Top level of the strided N-d copy address generator.
// Depends on sndc_pkg, sndc_cfg_regs, sndc_index_walker, sndc_addr_pipe, sndc_out_fifo.
//
// Usage:
//   Each item on the slave stream (tdata bit 0 = restart) produces one move item on
//   the master stream: source address, destination address and byte count in tdata,
//   tlast set on the final element of the walk. Restart zeroes the index counters
//   before the move is formed.
//   Registers are written through the APB port at byte address 8*index; the user must
//   write them only while no item is in flight, as the block does not enforce it.
//   Path: a move reaches the master side through the index register, the product
//   register and then the output FIFO entry.
//   Throughput: one item per cycle while tready is high; the odometer carry is combinational.
//   Stall: a four-entry output FIFO absorbs moves; tready on the slave side drops
//   once four items are accepted and not yet taken, and rises again as moves drain.
//   Reset: counters cleared, item_bytes = 4, all other registers zero, FIFO empty.
`default_nettype none

module strided_nd_copy_address_generator_top #(
  parameter int unsigned MAX_DIMS   = sndc_pkg::MAX_DIMS_DEF,
  parameter int unsigned FIELD_BITS = sndc_pkg::FIELD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = sndc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [sndc_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  wire logic [sndc_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic      [sndc_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                          pready,
  input  wire logic                                     s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // restart
  input  wire logic [sndc_pkg::IN_DATA_BITS-1:0]        s_axis_tdata_i,
  output logic                                          m_axis_tvalid_o,
  input  wire logic                                     m_axis_tready_i,
  // source_address, dest_address, move_bytes
  output logic      [((2*ADDR_BITS+sndc_pkg::BYTES_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                          m_axis_tlast_o
);
  import sndc_pkg::*;

  localparam int unsigned OUT_BITS = ((2 * ADDR_BITS + BYTES_BITS + 7) / 8) * 8;
  localparam int unsigned ENT_W    = 2 * ADDR_BITS + BYTES_BITS + 1;
  localparam int unsigned CRED_W   = $clog2(OUT_DEPTH + 1);

  logic [DIM_CNT_BITS-1:0]             dim_count;
  logic [BYTES_BITS-1:0]               item_bytes;
  logic [PACK_BITS-1:0]                extent;
  logic [PACK_BITS-1:0]                src_strides;
  logic [PACK_BITS-1:0]                dst_strides;
  logic [PACK_BITS-1:0]                src_start;
  logic [ADDR_BITS-1:0]                src_base;
  logic [ADDR_BITS-1:0]                dst_base;

  logic                                s_accept;
  logic                                m_accept;
  logic [CRED_W-1:0]                   inflight_q, inflight_d;

  logic                                s1_valid;
  logic [MAX_DIMS-1:0][FIELD_BITS-1:0] s1_idx;
  logic [MAX_DIMS-1:0]                 s1_used;
  logic                                s1_last;
  logic [BYTES_BITS-1:0]               s1_bytes;

  logic                                s2_valid;
  logic [ADDR_BITS-1:0]                s2_src;
  logic [ADDR_BITS-1:0]                s2_dst;
  logic [BYTES_BITS-1:0]               s2_bytes;
  logic                                s2_last;

  logic [ENT_W-1:0]                    fifo_out;

  sndc_cfg_regs #(
    .ADDR_BITS(ADDR_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dim_count_o  (dim_count),
    .item_bytes_o (item_bytes),
    .extent_o     (extent),
    .src_strides_o(src_strides),
    .dst_strides_o(dst_strides),
    .src_start_o  (src_start),
    .src_base_o   (src_base),
    .dst_base_o   (dst_base)
  );

  assign s_axis_tready_o = (32'(inflight_q) < OUT_DEPTH);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign m_accept        = m_axis_tvalid_o & m_axis_tready_i;
  assign inflight_d      = inflight_q + CRED_W'(s_accept) - CRED_W'(m_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  sndc_index_walker #(
    .MAX_DIMS  (MAX_DIMS),
    .FIELD_BITS(FIELD_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_accept),
    .restart_i   (s_axis_tdata_i[0]),
    .dim_count_i (dim_count),
    .item_bytes_i(item_bytes),
    .extent_i    (extent),
    .valid_o     (s1_valid),
    .idx_o       (s1_idx),
    .used_o      (s1_used),
    .last_o      (s1_last),
    .bytes_o     (s1_bytes)
  );

  sndc_addr_pipe #(
    .MAX_DIMS  (MAX_DIMS),
    .FIELD_BITS(FIELD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .idx_i        (s1_idx),
    .used_i       (s1_used),
    .last_i       (s1_last),
    .bytes_i      (s1_bytes),
    .src_strides_i(src_strides),
    .dst_strides_i(dst_strides),
    .src_start_i  (src_start),
    .src_base_i   (src_base),
    .dst_base_i   (dst_base),
    .valid_o      (s2_valid),
    .src_addr_o   (s2_src),
    .dst_addr_o   (s2_dst),
    .bytes_o      (s2_bytes),
    .last_o       (s2_last)
  );

  sndc_out_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(OUT_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s2_valid),
    .data_i ({s2_last, s2_bytes, s2_dst, s2_src}),
    .pop_i  (m_axis_tready_i),
    .valid_o(m_axis_tvalid_o),
    .data_o (fifo_out)
  );

  assign m_axis_tdata_o = OUT_BITS'(fifo_out[ENT_W-2:0]);
  assign m_axis_tlast_o = fifo_out[ENT_W-1];

endmodule

`default_nettype wire
